// ===== rtl/gwcs_pkg.sv =====
package gwcs_pkg;

	localparam int DEF_MAX_CANDIDATES = 64;
	localparam int SCORE_W            = 32;
	localparam int ROW_W              = 64;
	localparam int IDX_W              = 6;
	localparam int CNT_W              = 7;
	localparam int S_TDATA_W          = 96;
	localparam int M_TDATA_W          = 8;

	localparam logic [CNT_W-1:0] MAX_PICKS_RST = CNT_W'(64);

endpackage

// ===== rtl/greedy_weighted_compatible_selection_unit.sv =====
// channel | dir | signals                        | word
// s       | in  | s_tvalid s_tready s_tdata s_tlast | score, compat_row; tlast = last_candidate
// m       | out | m_tvalid m_tready m_tdata m_tlast m_tuser | pick_index; tlast = last_pick;
//         |     |                                | tuser = none_picked
// cfg     | in  | cfg_we cfg_wdata               | max_picks
//
// Load: one candidate word per cycle into the candidate memory.
// Selection: each visit scans all N loaded scores through one compare unit,
// then checks the compat row of the best score in ST_CHK, plus one ST_PUSH step per pick.
// A run is V visits and P picks, plus a closing scan that finds nothing when
// max_picks is not reached; output stalls add to it.
// Reset: asynchronous, control only; memories need no clearing.
// An m-side stall holds the sequencer only when a new result must enter the output register.
module greedy_weighted_compatible_selection_unit #(
	parameter int MAX_CANDIDATES = gwcs_pkg::DEF_MAX_CANDIDATES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gwcs_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] score, [95:32] compat_row
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gwcs_pkg::M_TDATA_W-1:0] m_tdata,  // [5:0] pick_index, [7:6] zero
	output logic                           m_tlast,
	output logic                           m_tuser,  // [0] none_picked
	input  logic                           cfg_we,
	input  logic [gwcs_pkg::CNT_W-1:0]     cfg_wdata
);
	import gwcs_pkg::*;

	localparam int AW = $clog2(MAX_CANDIDATES);
	localparam int CW = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CANDIDATES);

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_CHK  = 5'b00100,
		ST_PUSH = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                    st_q;
	logic [CNT_W-1:0]          max_picks_q;
	logic [CW-1:0]             loaded_q;
	logic [CW-1:0]             scan_idx_q;
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_idx_s1;
	logic                      best_vld_q;
	logic [AW-1:0]             best_q;
	logic [SCORE_W-1:0]        best_score_q;
	logic [MAX_CANDIDATES-1:0] picked_q;
	logic [MAX_CANDIDATES-1:0] visited_q;
	logic [CNT_W-1:0]          pick_cnt_q;
	logic                      pend_vld_q;
	logic [AW-1:0]             pend_q;
	logic                      m_tvalid_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic                      out_last_q;
	logic                      out_none_q;

	logic               in_acc;
	logic               wr_en;
	logic [SCORE_W-1:0] score_rd;
	logic [ROW_W-1:0]   row_rd;
	logic               out_free;
	logic               out_load;
	logic               scan_more;
	logic               cand_ok;
	logic               row_ok;
	logic               picks_full;

	assign s_tready   = (st_q == ST_LOAD);
	assign in_acc     = s_tvalid && s_tready;
	assign wr_en      = in_acc && (loaded_q < MAX_CNT);
	assign out_free   = !m_tvalid_q || m_tready;
	assign out_load   = out_free && (((st_q == ST_PUSH) && pend_vld_q) || (st_q == ST_FIN));
	assign scan_more  = (scan_idx_q < loaded_q);
	assign cand_ok    = rd_vld_s1 && !visited_q[rd_idx_s1] && !score_rd[SCORE_W-1]
	                    && (score_rd != '0) && (!best_vld_q || score_rd > best_score_q);
	assign row_ok     = ((row_rd[MAX_CANDIDATES-1:0] & picked_q) == picked_q);
	assign picks_full = (pick_cnt_q >= max_picks_q);

	gwcs_cand_mem #(
		.MAX_CANDIDATES(MAX_CANDIDATES),
		.AW            (AW)
	) u_mem (
		.clk        (clk),
		.we         (wr_en),
		.waddr      (loaded_q[AW-1:0]),
		.wscore     (s_tdata[SCORE_W-1:0]),
		.wrow       (s_tdata[SCORE_W +: ROW_W]),
		.score_raddr(scan_idx_q[AW-1:0]),
		.score_rdata(score_rd),
		.row_raddr  (best_q),
		.row_rdata  (row_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_picks_q <= MAX_PICKS_RST;
		end else if (cfg_we) begin
			max_picks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_LOAD;
			loaded_q   <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			picked_q   <= '0;
			visited_q  <= '0;
			pick_cnt_q <= '0;
			pend_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (wr_en) begin
							loaded_q <= loaded_q + CW'(1);
						end
						if (s_tlast) begin
							picked_q   <= '0;
							visited_q  <= '0;
							pick_cnt_q <= '0;
							scan_idx_q <= '0;
							rd_vld_s1  <= 1'b0;
							best_vld_q <= 1'b0;
							st_q       <= (max_picks_q == '0) ? ST_FIN : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= scan_more;
					rd_idx_s1 <= scan_idx_q[AW-1:0];
					if (scan_more) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
					if (cand_ok) begin
						best_vld_q   <= 1'b1;
						best_q       <= rd_idx_s1;
						best_score_q <= score_rd;
					end
					if (!scan_more && !rd_vld_s1) begin
						if (best_vld_q) begin
							visited_q[best_q] <= 1'b1;
							st_q              <= ST_CHK;
						end else begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_CHK: begin
					scan_idx_q <= '0;
					best_vld_q <= 1'b0;
					if (row_ok) begin
						picked_q[best_q] <= 1'b1;
						pick_cnt_q       <= pick_cnt_q + CNT_W'(1);
						st_q             <= ST_PUSH;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_PUSH: begin
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							out_idx_q  <= IDX_W'(pend_q);
							out_last_q <= 1'b0;
							out_none_q <= 1'b0;
						end
						pend_vld_q <= 1'b1;
						pend_q     <= best_q;
						st_q       <= picks_full ? ST_FIN : ST_SCAN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_idx_q  <= pend_vld_q ? IDX_W'(pend_q) : '0;
						out_last_q <= 1'b1;
						out_none_q <= !pend_vld_q;
						pend_vld_q <= 1'b0;
						loaded_q   <= '0;
						st_q       <= ST_LOAD;
					end
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(out_idx_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_none_q;

	a_load_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD) |-> !pend_vld_q)
		else $error("pending pick left over in load phase");

	a_picked_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(picked_q & ~visited_q) == '0)
		else $error("picked candidate never visited");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("none_picked word without last mark");

	a_pick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH) |-> (pick_cnt_q != '0 && pick_cnt_q <= max_picks_q))
		else $error("pick count out of range");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= MAX_CNT)
		else $error("loaded count beyond capacity");

endmodule

// ===== rtl/gwcs_cand_mem.sv =====
module gwcs_cand_mem #(
	parameter int MAX_CANDIDATES = gwcs_pkg::DEF_MAX_CANDIDATES,
	parameter int AW             = $clog2(MAX_CANDIDATES)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [gwcs_pkg::SCORE_W-1:0] wscore,
	input  logic [gwcs_pkg::ROW_W-1:0]   wrow,
	input  logic [AW-1:0]                score_raddr,
	output logic [gwcs_pkg::SCORE_W-1:0] score_rdata,
	input  logic [AW-1:0]                row_raddr,
	output logic [gwcs_pkg::ROW_W-1:0]   row_rdata
);
	import gwcs_pkg::*;

	logic [SCORE_W-1:0] score_mem [MAX_CANDIDATES];
	logic [ROW_W-1:0]   row_mem   [MAX_CANDIDATES];

	always_ff @(posedge clk) begin
		if (we) begin
			score_mem[waddr] <= wscore;
			row_mem[waddr]   <= wrow;
		end
		score_rdata <= score_mem[score_raddr];
		row_rdata   <= row_mem[row_raddr];
	end

endmodule
